// ===== rtl/rrss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin slice scheduler package
// Shared codes, widths and state type of the round-robin slice scheduler.
// ----------------------------------------------------------------------------
package rrss_pkg;

    localparam int DEFAULT_MAX_PROCESSES = 16;

    localparam int ID_W      = 16;
    localparam int TIME_W    = 16;
    localparam int ELAPSED_W = 24;
    localparam int PADDR_W   = 3;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam logic [TIME_W-1:0]    SLICE_RESET = 16'd4;

    localparam logic [PADDR_W-1:0] CFG_ADDR_SLICE = 3'd0;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_STEP   = 2'd2;

    localparam logic [1:0] STATUS_GRANT    = 2'd0;
    localparam logic [1:0] STATUS_ALL_DONE = 2'd1;
    localparam logic [1:0] STATUS_NONE     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_GRANT,
        S_RESULT
    } t_state;

endpackage

// ===== rtl/round_robin_slice_scheduler.sv =====
`timescale 1ns / 1ps
// Clear and append requests are taken in the idle state and the block stays ready for the next request.
// A step request visits the table entries through one read port, in S_READ and S_CHECK per entry.
// A granted step then passes through S_GRANT to S_RESULT, and a step that finds nothing pending
// goes straight to S_RESULT; S_RESULT loads the result register once it is free.
// The input is free again once the result register is loaded; a stalled result holds it off.
// Reset is synchronous and active low: the table is emptied and time_slice returns to 4.
// ----------------------------------------------------------------------------
// Round-robin slice scheduler
// Keeps a table of processes and hands out time slices to them in turn,
// with a small sequencer scanning the table one entry at a time.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler #(
    parameter int MAX_PROCESSES = rrss_pkg::DEFAULT_MAX_PROCESSES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // process_id, burst_time
    input  logic [1:0]                   s_axis_tuser,  // func
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [55:0]                  m_axis_tdata,  // served_id, remaining_after,
                                                        // elapsed_time
    output logic [1:0]                   m_axis_tuser,  // status
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rrss_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int IDX_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCESSES);

    rrss_pkg::t_state r_state, n_state;

    logic [rrss_pkg::ID_W-1:0]   mem_id  [MAX_PROCESSES];
    logic [rrss_pkg::TIME_W-1:0] mem_rem [MAX_PROCESSES];

    logic [rrss_pkg::TIME_W-1:0]    r_slice;
    logic [CNT_W-1:0]               r_count, n_count;
    logic [CNT_W-1:0]               r_fin, n_fin;
    logic [IDX_W-1:0]               r_next_pos, n_next_pos;
    logic [rrss_pkg::ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [IDX_W-1:0]               r_pos, n_pos;
    logic [CNT_W-1:0]               r_scan, n_scan;
    logic [rrss_pkg::ID_W-1:0]      r_rd_id;
    logic [rrss_pkg::TIME_W-1:0]    r_rd_rem;
    logic                           r_found, n_found;
    logic [rrss_pkg::ID_W-1:0]      r_res_id, n_res_id;
    logic [rrss_pkg::TIME_W-1:0]    r_res_rem, n_res_rem;

    logic                           r_out_valid, n_out_valid;
    logic [1:0]                     r_out_status, n_out_status;
    logic [rrss_pkg::ID_W-1:0]      r_out_id, n_out_id;
    logic [rrss_pkg::TIME_W-1:0]    r_out_rem, n_out_rem;
    logic [rrss_pkg::ELAPSED_W-1:0] r_out_elapsed, n_out_elapsed;

    logic                           w_rem_en, w_id_en;
    logic [IDX_W-1:0]               w_addr;
    logic [rrss_pkg::TIME_W-1:0]    w_rem;

    logic [rrss_pkg::TIME_W-1:0]    grant;
    logic [rrss_pkg::TIME_W-1:0]    new_rem;
    logic [rrss_pkg::ELAPSED_W:0]   elapsed_sum;
    logic [CNT_W-1:0]               pos_inc;
    logic                           out_free;
    logic                           cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr == rrss_pkg::CFG_ADDR_SLICE);
    assign prdata   = (paddr == rrss_pkg::CFG_ADDR_SLICE) ? {16'd0, r_slice} : 32'd0;

    assign s_axis_tready = (r_state == rrss_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {r_out_elapsed, r_out_rem, r_out_id};

    assign grant       = (r_slice < r_rd_rem) ? r_slice : r_rd_rem;
    assign new_rem     = r_rd_rem - grant;
    assign elapsed_sum = {1'b0, r_elapsed} + (rrss_pkg::ELAPSED_W + 1)'(grant);
    assign pos_inc     = CNT_W'(r_pos) + CNT_W'(1);
    assign out_free    = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= rrss_pkg::SLICE_RESET;
        end else if (cfg_wr) begin
            r_slice <= pwdata[rrss_pkg::TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rem_en) begin
            mem_rem[w_addr] <= w_rem;
        end
        if (w_id_en) begin
            mem_id[w_addr] <= s_axis_tdata[rrss_pkg::ID_W-1:0];
        end
        if (r_state == rrss_pkg::S_READ) begin
            r_rd_rem <= mem_rem[r_pos];
            r_rd_id  <= mem_id[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrss_pkg::S_IDLE;
            r_count     <= '0;
            r_fin       <= '0;
            r_next_pos  <= '0;
            r_elapsed   <= '0;
            r_pos       <= '0;
            r_scan      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_fin       <= n_fin;
            r_next_pos  <= n_next_pos;
            r_elapsed   <= n_elapsed;
            r_pos       <= n_pos;
            r_scan      <= n_scan;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_id      <= n_res_id;
        r_res_rem     <= n_res_rem;
        r_out_status  <= n_out_status;
        r_out_id      <= n_out_id;
        r_out_rem     <= n_out_rem;
        r_out_elapsed <= n_out_elapsed;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_fin         = r_fin;
        n_next_pos    = r_next_pos;
        n_elapsed     = r_elapsed;
        n_pos         = r_pos;
        n_scan        = r_scan;
        n_found       = r_found;
        n_res_id      = r_res_id;
        n_res_rem     = r_res_rem;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_status  = r_out_status;
        n_out_id      = r_out_id;
        n_out_rem     = r_out_rem;
        n_out_elapsed = r_out_elapsed;
        w_rem_en      = 1'b0;
        w_id_en       = 1'b0;
        w_addr        = r_pos;
        w_rem         = new_rem;

        unique case (r_state)
            rrss_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (s_axis_tuser)
                        rrss_pkg::FUNC_CLEAR: begin
                            n_count    = '0;
                            n_fin      = '0;
                            n_next_pos = '0;
                            n_elapsed  = '0;
                        end
                        rrss_pkg::FUNC_APPEND: begin
                            if (r_count < CNT_MAX) begin
                                w_rem_en = 1'b1;
                                w_id_en  = 1'b1;
                                w_addr   = r_count[IDX_W-1:0];
                                w_rem    = s_axis_tdata[31:16];
                                n_count  = r_count + CNT_W'(1);
                                if (s_axis_tdata[31:16] == '0) begin
                                    n_fin = r_fin + CNT_W'(1);
                                end
                            end
                        end
                        rrss_pkg::FUNC_STEP: begin
                            n_scan  = '0;
                            n_found = 1'b0;
                            n_pos   = (CNT_W'(r_next_pos) < r_count) ? r_next_pos : '0;
                            n_state = (r_count == '0) ? rrss_pkg::S_RESULT
                                                      : rrss_pkg::S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rrss_pkg::S_READ: begin
                n_state = rrss_pkg::S_CHECK;
            end
            rrss_pkg::S_CHECK: begin
                if (r_rd_rem != '0) begin
                    n_state = rrss_pkg::S_GRANT;
                end else begin
                    n_scan = r_scan + CNT_W'(1);
                    n_pos  = (pos_inc >= r_count) ? '0 : pos_inc[IDX_W-1:0];
                    n_state = (n_scan == r_count) ? rrss_pkg::S_RESULT
                                                  : rrss_pkg::S_READ;
                end
            end
            rrss_pkg::S_GRANT: begin
                w_rem_en   = 1'b1;
                n_found    = 1'b1;
                n_res_id   = r_rd_id;
                n_res_rem  = new_rem;
                n_next_pos = (pos_inc >= r_count) ? '0 : pos_inc[IDX_W-1:0];
                if (grant != '0 && new_rem == '0) begin
                    n_fin = r_fin + CNT_W'(1);
                end
                n_elapsed = elapsed_sum[rrss_pkg::ELAPSED_W]
                          ? rrss_pkg::ELAPSED_MAX
                          : elapsed_sum[rrss_pkg::ELAPSED_W-1:0];
                n_state = rrss_pkg::S_RESULT;
            end
            rrss_pkg::S_RESULT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_elapsed = r_elapsed;
                    if (r_found) begin
                        n_out_status = (r_fin >= r_count) ? rrss_pkg::STATUS_ALL_DONE
                                                          : rrss_pkg::STATUS_GRANT;
                        n_out_id     = r_res_id;
                        n_out_rem    = r_res_rem;
                    end else begin
                        n_out_status = rrss_pkg::STATUS_NONE;
                        n_out_id     = '0;
                        n_out_rem    = '0;
                    end
                    n_state = rrss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rrss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin slice scheduler checker
// Port-level assertions on the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rrss_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [55:0]                  m_axis_tdata,
    input logic [1:0]                   m_axis_tuser
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Stalled result changed.");

    a_none_has_no_process: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == rrss_pkg::STATUS_NONE |->
            m_axis_tdata[31:0] == 32'd0)
        else $error("Nothing-pending result carries a process.");

    a_all_done_is_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == rrss_pkg::STATUS_ALL_DONE |->
            m_axis_tdata[31:16] == 16'd0)
        else $error("All-finished result with remaining time.");

endmodule

bind round_robin_slice_scheduler rrss_checker u_rrss_checker (.*);
